[src/akf_pkg.sv]
// ----------------------------------------------------------------------------
// Angle/gyro Kalman filter package
// Shared types, register codes, sequencer step codes and saturation helper.
// ----------------------------------------------------------------------------
package akf_pkg;

	localparam int unsigned FRAC_BITS = 24;

	localparam logic [30:0] TIME_STEP_RST   = 31'd83886;
	localparam logic [30:0] ANGLE_NOISE_RST = 31'd33554;
	localparam logic [30:0] BIAS_NOISE_RST  = 31'd33554;
	localparam logic [30:0] MEAS_NOISE_RST  = 31'd503316;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_TIME_STEP   = 2'd0,
		REG_ANGLE_NOISE = 2'd1,
		REG_BIAS_NOISE  = 2'd2,
		REG_MEAS_NOISE  = 2'd3
	} reg_idx_t;

	// Destination of a multiply-accumulate result.
	typedef enum logic [2:0] {
		DST_RATE,
		DST_ANGLE,
		DST_BIAS,
		DST_P00,
		DST_P01,
		DST_P10,
		DST_P11
	} dest_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED,
		ST_SETUP,
		ST_DIV,
		ST_UPD,
		ST_DRAIN,
		ST_OUT
	} state_t;

	// Prediction steps, in issue order.
	localparam logic [2:0] PR_RATE  = 3'd0;
	localparam logic [2:0] PR_P00   = 3'd1;
	localparam logic [2:0] PR_ANGLE = 3'd2;
	localparam logic [2:0] PR_P01   = 3'd3;
	localparam logic [2:0] PR_P10   = 3'd4;
	localparam logic [2:0] PR_P11   = 3'd5;

	// Update steps, in issue order.
	localparam logic [2:0] UP_P10   = 3'd0;
	localparam logic [2:0] UP_P00   = 3'd1;
	localparam logic [2:0] UP_P11   = 3'd2;
	localparam logic [2:0] UP_P01   = 3'd3;
	localparam logic [2:0] UP_ANGLE = 3'd4;
	localparam logic [2:0] UP_BIAS  = 3'd5;

	localparam logic [2:0] STEP_LAST = 3'd5;

	// One operation for the shared unit: dest = sat(c +/- rnd(a * b >> 24)).
	typedef struct packed {
		logic signed [33:0] a;
		logic signed [31:0] b;
		logic signed [33:0] c;
		logic               sub;
		dest_t              dest;
	} mac_op_t;

	typedef struct packed {
		logic               vld;
		dest_t              dest;
		logic signed [31:0] value;
	} mac_wb_t;

	function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
		logic signed [31:0] r;
		if (v[41:31] == '0 || v[41:31] == '1) begin
			r = v[31:0];
		end else if (v[41]) begin
			r = Q_MIN;
		end else begin
			r = Q_MAX;
		end
		return r;
	endfunction

endpackage

[src/akf_in_if.sv]
// ----------------------------------------------------------------------------
// Sample channel
// Carries one measured angle and one raw gyro rate per word.
// ----------------------------------------------------------------------------
interface akf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] measured_angle;
	logic signed [15:0] gyro_rate;

	modport source (output valid, output measured_angle, output gyro_rate, input ready);
	modport sink (input valid, input measured_angle, input gyro_rate, output ready);
endinterface

[src/akf_out_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Carries the filtered angle and the bias estimate per word.
// ----------------------------------------------------------------------------
interface akf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] filtered_angle;
	logic signed [31:0] estimated_bias;

	modport source (output valid, output filtered_angle, output estimated_bias, input ready);
	modport sink (input valid, input filtered_angle, input estimated_bias, output ready);
endinterface

[src/akf_mac.sv]
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registers the product magnitude, then rounds, adds and saturates.
// ----------------------------------------------------------------------------
module akf_mac (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            issue,
	input  akf_pkg::mac_op_t op,
	output akf_pkg::mac_wb_t wb
);
	import akf_pkg::*;

	logic [32:0]        a_mag;
	logic [31:0]        b_mag;
	logic [64:0]        prod_full;
	logic [63:0]        prod_s1;
	logic               neg_s1;
	logic signed [33:0] c_s1;
	dest_t              dest_s1;
	logic               vld_s1;
	logic [63:0]        rnd_full;
	logic signed [41:0] c_ext;
	logic signed [41:0] r_ext;
	logic signed [41:0] sum;

	assign a_mag     = op.a[33] ? 33'(-op.a) : 33'(op.a);
	assign b_mag     = op.b[31] ? 32'(-op.b) : 32'(op.b);
	assign prod_full = 65'(a_mag) * 65'(b_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= prod_full[63:0];
			neg_s1  <= op.a[33] ^ op.b[31] ^ op.sub;
			c_s1    <= op.c;
			dest_s1 <= op.dest;
		end
	end

	// Round to nearest with ties away from zero on the magnitude.
	assign rnd_full = prod_s1 + (64'd1 << (FRAC_BITS - 1));
	assign c_ext    = 42'(c_s1);
	assign r_ext    = $signed({2'b00, rnd_full[63:FRAC_BITS]});
	assign sum      = neg_s1 ? c_ext - r_ext : c_ext + r_ext;

	assign wb.vld   = vld_s1;
	assign wb.dest  = dest_s1;
	assign wb.value = sat32(sum);

endmodule

[src/akf_div.sv]
// ----------------------------------------------------------------------------
// Gain divider
// Two restoring lanes share one divisor and give both gains, one bit a cycle.
// ----------------------------------------------------------------------------
module akf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num0,
	input  logic signed [31:0] num1,
	input  logic [31:0]        den,
	output logic               done,
	output logic signed [31:0] k0,
	output logic signed [31:0] k1
);
	import akf_pkg::*;

	logic signed [31:0] num [2];
	logic [31:0]        mag [2];
	logic [55:0]        dvd [2];
	logic               ovf [2];
	logic [32:0]        trial [2];
	logic               fits [2];
	logic [32:0]        diff [2];
	logic signed [31:0] kq [2];

	logic [31:0] rem_q [2];
	logic [31:0] low_q [2];
	logic [31:0] quo_q [2];
	logic        neg_q [2];
	logic        ovf_q [2];
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	assign num[0] = num0;
	assign num[1] = num1;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mag[i]   = num[i][31] ? 32'(-num[i]) : 32'(num[i]);
			// Half the divisor is added up front for round-to-nearest.
			dvd[i]   = {mag[i], 24'd0} + {25'd0, den[31:1]};
			ovf[i]   = {8'd0, dvd[i][55:32]} >= den;
			trial[i] = {rem_q[i], low_q[i][31]};
			fits[i]  = trial[i] >= {1'b0, den_q};
			diff[i]  = trial[i] - {1'b0, den_q};
			if (ovf_q[i]) begin
				kq[i] = neg_q[i] ? Q_MIN : Q_MAX;
			end else if (neg_q[i]) begin
				kq[i] = quo_q[i][31] ? Q_MIN : -$signed(quo_q[i]);
			end else begin
				kq[i] = quo_q[i][31] ? Q_MAX : $signed(quo_q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_q == 6'd1;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				busy_q <= cnt_q != 6'd1;
				cnt_q  <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= ovf[i] ? 32'd0 : {8'd0, dvd[i][55:32]};
				low_q[i] <= dvd[i][31:0];
				quo_q[i] <= '0;
				neg_q[i] <= num[i][31];
				ovf_q[i] <= ovf[i];
			end
		end else if (busy_q) begin
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= fits[i] ? diff[i][31:0] : trial[i][31:0];
				low_q[i] <= {low_q[i][30:0], 1'b0};
				quo_q[i] <= {quo_q[i][30:0], fits[i]};
			end
		end
	end

	assign done = done_q;
	assign k0   = kq[0];
	assign k1   = kq[1];

endmodule

[src/angle_gyro_kalman_filter.sv]
// ----------------------------------------------------------------------------
// Angle/gyro Kalman filter
// Two-state fixed-point Kalman filter fusing a measured angle with a gyro rate.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word contents                         Handshake
//  sample   in   measured_angle Q16.16, gyro_rate      valid/ready
//  result   out  filtered_angle, estimated_bias Q16.16 valid/ready
//  apb      in   time_step, noise registers (Q8.24)    psel/penable, pready=1
//
//  A word is taken only in the idle state and runs through six prediction
//  operations, a setup step, a two-lane gain division, six update operations,
//  a drain step and the result state. All multiplies go through the one
//  shared multiply-accumulate unit. Reset clears the estimates, the covariance
//  and the registers to their defaults. A stalled result keeps new words out.
// ----------------------------------------------------------------------------
module angle_gyro_kalman_filter (
	input  logic          clk,
	input  logic          arst_n,
	akf_in_if.sink        sample,
	akf_out_if.source     result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import akf_pkg::*;

	logic [30:0] time_step_q;
	logic [30:0] angle_noise_q;
	logic [30:0] bias_noise_q;
	logic [30:0] meas_noise_q;

	logic signed [31:0] angle_q;
	logic signed [31:0] bias_q;
	logic signed [31:0] p00_q;
	logic signed [31:0] p01_q;
	logic signed [31:0] p10_q;
	logic signed [31:0] p11_q;
	logic signed [31:0] rate_q;
	logic signed [31:0] meas_q;
	logic signed [15:0] gyro_q;
	logic signed [32:0] e_q;
	logic               gain_en_q;

	state_t     state_q;
	state_t     state_d;
	logic [2:0] step_q;

	logic               mac_issue;
	mac_op_t            mac_op;
	mac_wb_t            wb;
	logic               div_start;
	logic               div_done;
	logic signed [31:0] div_k0;
	logic signed [31:0] div_k1;
	logic signed [31:0] k0;
	logic signed [31:0] k1;
	logic signed [31:0] dt;
	logic signed [32:0] innov_var;
	logic               apb_wr;

	assign dt        = $signed({1'b0, time_step_q});
	assign innov_var = 33'(p00_q) + 33'($signed({1'b0, meas_noise_q}));
	assign k0        = gain_en_q ? div_k0 : '0;
	assign k1        = gain_en_q ? div_k1 : '0;

	// Configuration port.
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q   <= TIME_STEP_RST;
			angle_noise_q <= ANGLE_NOISE_RST;
			bias_noise_q  <= BIAS_NOISE_RST;
			meas_noise_q  <= MEAS_NOISE_RST;
		end else if (apb_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_TIME_STEP: begin
					time_step_q <= pwdata[30:0];
				end
				REG_ANGLE_NOISE: begin
					angle_noise_q <= pwdata[30:0];
				end
				REG_BIAS_NOISE: begin
					bias_noise_q <= pwdata[30:0];
				end
				REG_MEAS_NOISE: begin
					meas_noise_q <= pwdata[30:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_TIME_STEP:   prdata = {1'b0, time_step_q};
			REG_ANGLE_NOISE: prdata = {1'b0, angle_noise_q};
			REG_BIAS_NOISE:  prdata = {1'b0, bias_noise_q};
			REG_MEAS_NOISE:  prdata = {1'b0, meas_noise_q};
			default:         prdata = '0;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PRED || state_q == ST_UPD) begin
				step_q <= (step_q == STEP_LAST) ? 3'd0 : step_q + 3'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample.valid) state_d = ST_PRED;
			end
			ST_PRED: begin
				if (step_q == STEP_LAST) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_UPD;
			end
			ST_UPD: begin
				if (step_q == STEP_LAST) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (result.ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Operation issue. The order keeps every operand read before the unit
	// writes its replacement, since each result passes the unit's register first.
	always_comb begin
		mac_op    = '0;
		mac_issue = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_PRED: begin
				mac_issue = 1'b1;
				case (step_q)
					PR_RATE: begin
						mac_op.c    = 34'($signed({gyro_q, 16'd0})) - 34'(bias_q);
						mac_op.dest = DST_RATE;
					end
					PR_P00: begin
						mac_op.a    = 34'(p01_q) + 34'(p10_q);
						mac_op.b    = dt;
						mac_op.c    = 34'(p00_q) + 34'($signed({1'b0, angle_noise_q}));
						mac_op.sub  = 1'b1;
						mac_op.dest = DST_P00;
					end
					PR_ANGLE: begin
						mac_op.a    = 34'(rate_q);
						mac_op.b    = dt;
						mac_op.c    = 34'(angle_q);
						mac_op.dest = DST_ANGLE;
					end
					PR_P01: begin
						mac_op.a    = 34'(p11_q);
						mac_op.b    = dt;
						mac_op.c    = 34'(p01_q);
						mac_op.sub  = 1'b1;
						mac_op.dest = DST_P01;
					end
					PR_P10: begin
						mac_op.a    = 34'(p11_q);
						mac_op.b    = dt;
						mac_op.c    = 34'(p10_q);
						mac_op.sub  = 1'b1;
						mac_op.dest = DST_P10;
					end
					PR_P11: begin
						mac_op.c    = 34'(p11_q) + 34'($signed({1'b0, bias_noise_q}));
						mac_op.dest = DST_P11;
					end
					default: begin
						mac_issue = 1'b0;
					end
				endcase
			end
			ST_SETUP: begin
				div_start = 1'b1;
			end
			ST_UPD: begin
				mac_issue  = 1'b1;
				mac_op.sub = 1'b1;
				case (step_q)
					UP_P10: begin
						mac_op.a    = 34'(p00_q);
						mac_op.b    = k1;
						mac_op.c    = 34'(p10_q);
						mac_op.dest = DST_P10;
					end
					UP_P00: begin
						mac_op.a    = 34'(p00_q);
						mac_op.b    = k0;
						mac_op.c    = 34'(p00_q);
						mac_op.dest = DST_P00;
					end
					UP_P11: begin
						mac_op.a    = 34'(p01_q);
						mac_op.b    = k1;
						mac_op.c    = 34'(p11_q);
						mac_op.dest = DST_P11;
					end
					UP_P01: begin
						mac_op.a    = 34'(p01_q);
						mac_op.b    = k0;
						mac_op.c    = 34'(p01_q);
						mac_op.dest = DST_P01;
					end
					UP_ANGLE: begin
						mac_op.a    = 34'(e_q);
						mac_op.b    = k0;
						mac_op.c    = 34'(angle_q);
						mac_op.sub  = 1'b0;
						mac_op.dest = DST_ANGLE;
					end
					UP_BIAS: begin
						mac_op.a    = 34'(e_q);
						mac_op.b    = k1;
						mac_op.c    = 34'(bias_q);
						mac_op.sub  = 1'b0;
						mac_op.dest = DST_BIAS;
					end
					default: begin
						mac_issue = 1'b0;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	akf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (mac_issue),
		.op     (mac_op),
		.wb     (wb)
	);

	akf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num0   (p00_q),
		.num1   (p10_q),
		.den    (innov_var[31:0]),
		.done   (div_done),
		.k0     (div_k0),
		.k1     (div_k1)
	);

	// Filter state and result write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			bias_q  <= '0;
			p00_q   <= '0;
			p01_q   <= '0;
			p10_q   <= '0;
			p11_q   <= '0;
		end else if (wb.vld) begin
			case (wb.dest)
				DST_ANGLE: angle_q <= wb.value;
				DST_BIAS:  bias_q  <= wb.value;
				DST_P00:   p00_q   <= wb.value;
				DST_P01:   p01_q   <= wb.value;
				DST_P10:   p10_q   <= wb.value;
				DST_P11:   p11_q   <= wb.value;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wb.vld && wb.dest == DST_RATE) begin
			rate_q <= wb.value;
		end
		if (sample.valid && sample.ready) begin
			meas_q <= sample.measured_angle;
			gyro_q <= sample.gyro_rate;
		end
		// The innovation is taken once, against the predicted angle.
		if (state_q == ST_SETUP) begin
			e_q       <= 33'(meas_q) - 33'(angle_q);
			gain_en_q <= !innov_var[32] && innov_var != '0;
		end
	end

	assign sample.ready          = state_q == ST_IDLE;
	assign result.valid          = state_q == ST_OUT;
	assign result.filtered_angle = angle_q;
	assign result.estimated_bias = bias_q;

	a_no_accept_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !sample.ready)
		else $error("sample accepted while a result word is pending");

	a_wb_in_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		wb.vld |-> (state_q == ST_PRED || state_q == ST_SETUP ||
			state_q == ST_UPD || state_q == ST_DRAIN))
		else $error("multiply-accumulate write-back outside the sequence");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the division state");

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q) == ST_DRAIN)
		else $error("result word raised before the update completed");

endmodule

[tb/sv/angle_filter_checker.sv]
// ----------------------------------------------------------------------------
// Angle/gyro Kalman filter checker
// Watches the sample, result and register ports, runs a fixed-point filter of
// its own on every accepted sample word and compares each result word with the
// oldest estimate still due. Register reads are checked against the settings.
// ----------------------------------------------------------------------------
module angle_filter_checker (
	input  logic        clk,
	input  logic        arst_n,
	akf_in_if           sample,
	akf_out_if          result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	output int unsigned mismatches,
	output int unsigned estimates_pending
);
	import akf_pkg::*;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] bias;
	} estimate_t;

	estimate_t          estimates_due[$];
	logic [30:0]        settings[4];
	logic signed [31:0] angle_est;
	logic signed [31:0] bias_est;
	logic signed [31:0] p00;
	logic signed [31:0] p01;
	logic signed [31:0] p10;
	logic signed [31:0] p11;

	function automatic longint clamp32(input longint v);
		if (v > longint'(Q_MAX)) return longint'(Q_MAX);
		if (v < longint'(Q_MIN)) return longint'(Q_MIN);
		return v;
	endfunction

	// Q8.24 product, rounded to nearest with ties away from zero.
	function automatic longint scale_q24(input longint a, input longint b);
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] prod;
		ma = (a < 0) ? 64'(-a) : 64'(a);
		mb = (b < 0) ? 64'(-b) : 64'(b);
		prod = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return ((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod);
	endfunction

	function automatic longint gain_q24(input longint num, input longint den);
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] q;
		n = ((num < 0) ? 64'(-num) : 64'(num)) << FRAC_BITS;
		d = 64'(den);
		q = (n + d / 2) / d;
		if (q > 64'h8000_0000) q = 64'h8000_0000;
		return clamp32((num < 0) ? -longint'(q) : longint'(q));
	endfunction

	// One predict and update step; returns the estimates that the word must carry.
	function automatic estimate_t advance_filter(input logic signed [31:0] meas,
			input logic signed [15:0] gyro);
		longint    dt;
		longint    rate;
		longint    s;
		longint    e;
		longint    k0;
		longint    k1;
		longint    n00;
		longint    n01;
		longint    n10;
		longint    n11;
		estimate_t est;
		dt = longint'(settings[REG_TIME_STEP]);
		rate = clamp32(longint'(gyro) * 65536 - longint'(bias_est));
		angle_est = 32'(clamp32(longint'(angle_est) + scale_q24(rate, dt)));
		n00 = clamp32(longint'(p00) - scale_q24(longint'(p01) + longint'(p10), dt)
			+ longint'(settings[REG_ANGLE_NOISE]));
		n01 = clamp32(longint'(p01) - scale_q24(longint'(p11), dt));
		n10 = clamp32(longint'(p10) - scale_q24(longint'(p11), dt));
		n11 = clamp32(longint'(p11) + longint'(settings[REG_BIAS_NOISE]));
		// A non-positive innovation variance leaves both gains at zero.
		k0 = 0;
		k1 = 0;
		s = n00 + longint'(settings[REG_MEAS_NOISE]);
		if (s > 0) begin
			k0 = gain_q24(n00, s);
			k1 = gain_q24(n10, s);
		end
		e = longint'(meas) - longint'(angle_est);
		angle_est = 32'(clamp32(longint'(angle_est) + scale_q24(k0, e)));
		bias_est = 32'(clamp32(longint'(bias_est) + scale_q24(k1, e)));
		p00 = 32'(clamp32(n00 - scale_q24(k0, n00)));
		p01 = 32'(clamp32(n01 - scale_q24(k0, n01)));
		p10 = 32'(clamp32(n10 - scale_q24(k1, n00)));
		p11 = 32'(clamp32(n11 - scale_q24(k1, n01)));
		est.angle = angle_est;
		est.bias = bias_est;
		return est;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		estimate_t want;
		if (!arst_n) begin
			estimates_due.delete();
			settings[REG_TIME_STEP] = TIME_STEP_RST;
			settings[REG_ANGLE_NOISE] = ANGLE_NOISE_RST;
			settings[REG_BIAS_NOISE] = BIAS_NOISE_RST;
			settings[REG_MEAS_NOISE] = MEAS_NOISE_RST;
			angle_est = '0;
			bias_est = '0;
			p00 = '0;
			p01 = '0;
			p10 = '0;
			p11 = '0;
			mismatches = 0;
			estimates_pending <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					settings[paddr[3:2]] = pwdata[30:0];
				end else if (prdata !== {1'b0, settings[paddr[3:2]]}) begin
					mismatches++;
					$error("register %0d: expected %0d, got %0d",
						paddr[3:2], {1'b0, settings[paddr[3:2]]}, prdata);
				end
			end
			if (sample.valid && sample.ready) begin
				estimates_due.push_back(advance_filter(sample.measured_angle, sample.gyro_rate));
			end
			if (result.valid && result.ready) begin
				if (estimates_due.size() == 0) begin
					mismatches++;
					$error("result word with no estimate due: angle %0d, bias %0d",
						result.filtered_angle, result.estimated_bias);
				end else begin
					want = estimates_due.pop_front();
					if (result.filtered_angle !== want.angle) begin
						mismatches++;
						$error("filtered_angle: expected %0d, got %0d",
							want.angle, result.filtered_angle);
					end
					if (result.estimated_bias !== want.bias) begin
						mismatches++;
						$error("estimated_bias: expected %0d, got %0d",
							want.bias, result.estimated_bias);
					end
				end
			end
			estimates_pending <= estimates_due.size();
		end
	end

endmodule

[tb/sv/tb_angle_gyro_kalman_filter.sv]
// ----------------------------------------------------------------------------
// Angle/gyro Kalman filter testbench
// Drives sample words in random bursts through several register settings,
// starting with field extremes and saturating settings, then mostly smooth
// motion with noise. Stalls the result side on its own patterns, including one
// long hold-off, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_angle_gyro_kalman_filter;
	import akf_pkg::*;

	localparam int unsigned CLK_PERIOD   = 12;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned PHASE_WORDS  = 178;
	localparam int unsigned PAUSE_PHASE  = 3;
	localparam int unsigned HOLD_PHASE   = 6;
	localparam int unsigned HOLD_WORDS   = 16;
	localparam int unsigned LONG_HOLD    = 600;
	localparam int unsigned TAIL_CYCLES  = 80;
	localparam longint      RUN_LIMIT    = 64'd1_000_000 * CLK_PERIOD;
	localparam longint      ANGLE_SPAN   = 64'sd180 * 65536;

	typedef enum logic [1:0] {
		SET_TYPICAL,
		SET_RANDOM,
		SET_ALL_MAX,
		SET_DEFAULT
	} setting_kind_t;

	typedef enum logic [1:0] {
		DRAIN_FREE,
		DRAIN_COIN,
		DRAIN_PERIODIC,
		DRAIN_SPARSE
	} drain_style_t;

	localparam setting_kind_t PLAN[PHASES] = '{SET_TYPICAL, SET_RANDOM, SET_ALL_MAX,
		SET_TYPICAL, SET_RANDOM, SET_DEFAULT, SET_TYPICAL, SET_TYPICAL};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int unsigned mismatches;
	int unsigned estimates_pending;
	int unsigned hold_asked = 0;
	int unsigned hold_served = 0;

	// Motion that the well-formed sample words follow.
	longint      true_angle = 0;
	int          true_rate = 0;
	int          gyro_offset = 0;

	akf_in_if  sample ();
	akf_out_if result ();

	angle_gyro_kalman_filter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	angle_filter_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.sample            (sample),
		.result            (result),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.pready            (pready),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.mismatches        (mismatches),
		.estimates_pending (estimates_pending)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_word(input logic signed [31:0] ang, input logic signed [15:0] rate);
		sample.valid <= 1'b1;
		sample.measured_angle <= ang;
		sample.gyro_rate <= rate;
		@(posedge clk);
		while (sample.ready !== 1'b1) @(posedge clk);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		if (cycles != 0) begin
			sample.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic idle_until_drained();
		sample.valid <= 1'b0;
		@(posedge clk);
		while (estimates_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_access(input logic wr, input reg_idx_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_back_all();
		for (int i = 0; i < 4; i++) reg_access(1'b0, reg_idx_t'(i), '0);
	endtask

	// Bit 31 of each register word is junk that the block must drop.
	task automatic apply_settings(input logic [30:0] dt, input logic [30:0] qa,
			input logic [30:0] qb, input logic [30:0] r);
		idle_until_drained();
		reg_access(1'b1, REG_TIME_STEP, {1'($urandom_range(0, 1)), dt});
		reg_access(1'b1, REG_ANGLE_NOISE, {1'($urandom_range(0, 1)), qa});
		reg_access(1'b1, REG_BIAS_NOISE, {1'($urandom_range(0, 1)), qb});
		reg_access(1'b1, REG_MEAS_NOISE, {1'($urandom_range(0, 1)), r});
		read_back_all();
	endtask

	task automatic make_sample(input logic wild_ok, output logic signed [31:0] ang,
			output logic signed [15:0] rate);
		int unsigned pick;
		pick = wild_ok ? $urandom_range(0, 9) : 9;
		if (pick == 0) begin
			ang = $urandom();
			rate = 16'($urandom());
		end else if (pick == 1) begin
			case ($urandom_range(0, 3))
				0: ang = Q_MAX;
				1: ang = Q_MIN;
				2: ang = '0;
				default: ang = '1;
			endcase
			case ($urandom_range(0, 3))
				0: rate = 16'sh7FFF;
				1: rate = 16'sh8000;
				2: rate = '0;
				default: rate = '1;
			endcase
		end else begin
			if ($urandom_range(0, 19) == 0) true_rate = int'($urandom_range(0, 400)) - 200;
			// One step is 1/200 s, so a whole unit per second moves 327 LSBs.
			true_angle += longint'(true_rate) * 327;
			if (true_angle > ANGLE_SPAN || true_angle < -ANGLE_SPAN) begin
				true_rate = -true_rate;
				true_angle = (true_angle > 0) ? ANGLE_SPAN : -ANGLE_SPAN;
			end
			ang = 32'(true_angle + longint'($urandom_range(0, 262144)) - 131072);
			rate = 16'(true_rate + gyro_offset + int'($urandom_range(0, 6)) - 3);
		end
	endtask

	task automatic feed(input int unsigned count);
		int unsigned        burst_left;
		logic signed [31:0] ang;
		logic signed [15:0] rate;
		burst_left = 0;
		for (int unsigned n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 60));
			end
			make_sample(1'b1, ang, rate);
			send_word(ang, rate);
			burst_left--;
		end
	endtask

	initial begin : result_drain
		drain_style_t style;
		int unsigned  span;
		result.ready <= 1'b0;
		forever begin
			style = drain_style_t'($urandom_range(0, 3));
			span = $urandom_range(40, 400);
			for (int unsigned c = 0; c < span; c++) begin
				@(posedge clk);
				if (hold_served != hold_asked) begin
					hold_served = hold_asked;
					result.ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end
				case (style)
					DRAIN_FREE:     result.ready <= 1'b1;
					DRAIN_COIN:     result.ready <= 1'($urandom_range(0, 1));
					DRAIN_PERIODIC: result.ready <= (c % 7) >= 3;
					default:        result.ready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		logic signed [31:0] ang;
		logic signed [15:0] rate;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample.valid <= 1'b0;
		sample.measured_angle <= '0;
		sample.gyro_rate <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_back_all();

		// Field extremes and bit patterns with the reset settings.
		send_word(32'sd0, 16'sd0);
		send_word(Q_MAX, 16'sd0);
		send_word(Q_MIN, 16'sd0);
		send_word(32'sd0, 16'sh7FFF);
		send_word(32'sd0, 16'sh8000);
		send_word(Q_MAX, 16'sh7FFF);
		send_word(Q_MIN, 16'sh8000);
		send_word(-32'sd1, -16'sd1);
		send_word(32'sh5555_5555, 16'sh5555);
		send_word(32'shAAAA_AAAA, 16'shAAAA);
		send_word(32'sd65536, 16'sd1);
		for (int i = 0; i < 3; i++) begin
			make_sample(1'b0, ang, rate);
			send_word(ang, rate);
		end

		// Longest step with the largest noise drives the covariance into saturation.
		apply_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1);
		send_word(Q_MAX, 16'sh7FFF);
		send_word(Q_MIN, 16'sh8000);
		send_word(32'sd0, 16'sd0);
		send_word(Q_MAX, 16'sh8000);
		send_word(Q_MIN, 16'sh7FFF);
		send_word(32'sd0, 16'sd0);

		// No time step and no process noise: the prediction stands still.
		apply_settings(31'd0, 31'd0, 31'd0, 31'h7FFF_FFFF);
		send_word(Q_MAX, 16'sh7FFF);
		send_word(Q_MIN, 16'sh8000);
		send_word(32'sd0, 16'sd0);
		send_word(-32'sd1, -16'sd1);

		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			case (PLAN[ph])
				SET_TYPICAL: apply_settings(31'($urandom_range(16777, 1677722)),
					31'($urandom_range(0, 838861)), 31'($urandom_range(0, 838861)),
					31'($urandom_range(16777, 16777216)));
				SET_RANDOM: apply_settings(31'($urandom()), 31'($urandom()), 31'($urandom()),
					31'($urandom_range(1, 32'h7FFF_FFFF)));
				SET_ALL_MAX: apply_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
					31'h7FFF_FFFF);
				default: apply_settings(TIME_STEP_RST, ANGLE_NOISE_RST, BIAS_NOISE_RST,
					MEAS_NOISE_RST);
			endcase
			gyro_offset = int'($urandom_range(0, 100)) - 50;
			feed(PHASE_WORDS / 2);
			if (ph == PAUSE_PHASE) idle_until_drained();
			if (ph == HOLD_PHASE) begin
				// The result side holds off while words keep coming, so the input backs up.
				hold_asked++;
				for (int unsigned n = 0; n < HOLD_WORDS; n++) begin
					make_sample(1'b1, ang, rate);
					send_word(ang, rate);
				end
			end
			feed(PHASE_WORDS - PHASE_WORDS / 2);
		end

		idle_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
